// ===== hdl/three_way_interval_intersection_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-way interval intersection block
// Clocked concurrent assertion helpers, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef THREE_WAY_INTERVAL_INTERSECTION_ASSERT_SVH
`define THREE_WAY_INTERVAL_INTERSECTION_ASSERT_SVH

// checked only while out of reset
`define TWII_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define TWII_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// ===== hdl/twii_pkg.sv =====
// ----------------------------------------------------------------------------
// twii_pkg
// Types, constants and helpers for the three-way interval intersection.
// ----------------------------------------------------------------------------
package twii_pkg;

  localparam int FifoDepthDef = 16;
  localparam int SourcesDef   = 3;
  localparam int MaxResults   = 32;
  localparam int SecW         = 32;
  localparam int NsecW        = 30;
  localparam int TimeW        = SecW + NsecW;

  localparam logic [1:0] KIND_COMMON = 2'd0;
  localparam logic [1:0] KIND_NONE   = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  typedef struct packed {
    logic [1:0]       source;
    logic [SecW-1:0]  begin_sec;
    logic [NsecW-1:0] begin_nsec;
    logic [SecW-1:0]  finish_sec;
    logic [NsecW-1:0] finish_nsec;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SecW-1:0]  common_begin_sec;
    logic [NsecW-1:0] common_begin_nsec;
    logic [SecW-1:0]  common_finish_sec;
    logic [NsecW-1:0] common_finish_nsec;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_LAT_RD,
    ST_LAT_EV,
    ST_FIN_RD,
    ST_FIN_EV,
    ST_EMIT,
    ST_FINAL
  } state_e;

  function automatic out_item_t make_result(logic [1:0] kind, logic [TimeW-1:0] b,
                                            logic [TimeW-1:0] f, logic last);
    out_item_t r;
    r.kind               = kind;
    r.common_begin_sec   = b[TimeW-1:NsecW];
    r.common_begin_nsec  = b[NsecW-1:0];
    r.common_finish_sec  = f[TimeW-1:NsecW];
    r.common_finish_nsec = f[NsecW-1:0];
    r.last               = last;
    return r;
  endfunction

endpackage

// ===== hdl/twii_ram.sv =====
// ----------------------------------------------------------------------------
// twii_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/three_way_interval_intersection.sv =====
// Sequence: a push with nothing to drain passes idle, write, check and final;
//   a dropped push skips write, and final repeats when a drop follows commons;
//   a round that emits reads every head for the latest begin, then for the
//   earliest finish, then emits; a round that drops stops at the stale head.
// Throughput: one item at a time; input stalls until its last result is in
//   the output register. Reset: control, fill counts and head pointers clear.
// ----------------------------------------------------------------------------
// three_way_interval_intersection
// Per-source interval FIFOs in one RAM; a small sequencer scans the heads to
// drop stale intervals and emit the common interval of all sources.
// ----------------------------------------------------------------------------
module three_way_interval_intersection #(
  parameter int FIFO_DEPTH = twii_pkg::FifoDepthDef,
  parameter int SOURCES    = twii_pkg::SourcesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  twii_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output twii_pkg::out_item_t out_item_o
);

  import twii_pkg::*;

  localparam int SW    = $clog2(SOURCES);
  localparam int SRCW  = (SW > 2) ? SW : 2;
  localparam int HW    = $clog2(FIFO_DEPTH);
  localparam int CW    = $clog2(FIFO_DEPTH + 1);
  localparam int AW    = $clog2(SOURCES * FIFO_DEPTH);
  localparam int NW    = $clog2(MaxResults + 1);
  localparam int RAMW  = 2 * TimeW;

  state_e state_q, state_d;

  logic [HW-1:0]    head_q [SOURCES];
  logic [CW-1:0]    fill_q [SOURCES];
  logic [SW-1:0]    cur_q;
  logic [SW-1:0]    early_src_q;
  logic             rej_q;
  logic [NW-1:0]    n_q;
  logic [TimeW-1:0] latest_q, early_q;
  logic [TimeW-1:0] in_b_q, in_f_q;
  logic [RAMW-1:0]  pend_q;
  logic             pend_v_q;
  logic             out_valid_q;
  out_item_t        out_q;

  // source selection shared by rejection check and RAM addressing
  logic [SRCW-1:0]  in_src_ext;
  logic [SW-1:0]    sel;
  logic [HW-1:0]    head_sel;
  logic [CW-1:0]    fill_sel;
  logic             in_accept, rejected, all_nz, last_s, slot_free, below_cap;
  logic [CW:0]      slot_sum;
  logic [HW-1:0]    slot;
  logic [AW-1:0]    ram_addr;
  logic [RAMW-1:0]  ram_rdata;
  logic [TimeW-1:0] rd_begin, rd_finish;
  logic             fin_drop, fin_better;

  logic             ram_we, ram_re, push_en, pop_en, out_load, emit_go;
  out_item_t        out_next;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_src_ext = SRCW'(in_item_i.source);
  assign sel        = (state_q == ST_IDLE) ? in_src_ext[SW-1:0] : cur_q;

  always_comb begin
    head_sel = '0;
    fill_sel = '0;
    all_nz   = 1'b1;
    for (int s = 0; s < SOURCES; s++) begin
      if (sel == SW'(s)) begin
        head_sel = head_q[s];
        fill_sel = fill_q[s];
      end
      if (fill_q[s] == '0) begin
        all_nz = 1'b0;
      end
    end
  end

  assign rejected = (int'(in_item_i.source) >= SOURCES) ||
                    (fill_sel >= CW'(FIFO_DEPTH));

  // tail slot on write, head slot on scans
  assign slot_sum = (CW+1)'(head_sel) + ((state_q == ST_WRITE) ? (CW+1)'(fill_sel) : '0);
  assign slot     = (slot_sum >= (CW+1)'(FIFO_DEPTH)) ?
                    HW'(slot_sum - (CW+1)'(FIFO_DEPTH)) : HW'(slot_sum);
  assign ram_addr = AW'(sel) * AW'(FIFO_DEPTH) + AW'(slot);

  twii_ram #(
    .WIDTH(RAMW),
    .DEPTH(SOURCES * FIFO_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i({in_b_q, in_f_q}),
    .re_i   (ram_re),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  assign rd_begin   = ram_rdata[RAMW-1:TimeW];
  assign rd_finish  = ram_rdata[TimeW-1:0];
  assign fin_drop   = rd_finish <= latest_q;
  assign fin_better = (cur_q == '0) || (rd_finish < early_q);
  assign last_s     = cur_q == SW'(SOURCES - 1);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign below_cap  = rej_q ? (n_q < NW'(MaxResults - 1)) : (n_q < NW'(MaxResults));
  assign emit_go    = !pend_v_q || slot_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_accept) state_d = rejected ? ST_CHECK : ST_WRITE;
      ST_WRITE:  state_d = ST_CHECK;
      ST_CHECK:  state_d = (all_nz && below_cap) ? ST_LAT_RD : ST_FINAL;
      ST_LAT_RD: state_d = ST_LAT_EV;
      ST_LAT_EV: state_d = last_s ? ST_FIN_RD : ST_LAT_RD;
      ST_FIN_RD: state_d = ST_FIN_EV;
      ST_FIN_EV: begin
        if (fin_drop) begin
          state_d = ST_CHECK;
        end else begin
          state_d = last_s ? ST_EMIT : ST_FIN_RD;
        end
      end
      ST_EMIT:   if (emit_go) state_d = ST_CHECK;
      ST_FINAL: begin
        if (slot_free) begin
          state_d = (pend_v_q && rej_q) ? ST_FINAL : ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    push_en  = 1'b0;
    pop_en   = 1'b0;
    out_load = 1'b0;
    out_next = make_result(KIND_COMMON, pend_q[RAMW-1:TimeW], pend_q[TimeW-1:0], 1'b0);
    case (state_q)
      ST_WRITE: begin
        ram_we  = 1'b1;
        push_en = 1'b1;
      end
      ST_LAT_RD, ST_FIN_RD: ram_re = 1'b1;
      ST_FIN_EV: pop_en = fin_drop;
      ST_EMIT: begin
        pop_en   = emit_go;
        out_load = pend_v_q && slot_free;
      end
      ST_FINAL: begin
        out_load = slot_free;
        if (pend_v_q) begin
          out_next.last = !rej_q;
        end else begin
          out_next = make_result(rej_q ? KIND_DROP : KIND_NONE, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // FIFO pointers and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SOURCES; s++) begin
        head_q[s] <= '0;
        fill_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < SOURCES; s++) begin
        if (cur_q == SW'(s)) begin
          if (push_en) begin
            fill_q[s] <= fill_q[s] + 1'b1;
          end else if (pop_en) begin
            fill_q[s] <= fill_q[s] - 1'b1;
            head_q[s] <= (head_q[s] == HW'(FIFO_DEPTH - 1)) ? '0 : head_q[s] + 1'b1;
          end
        end
      end
    end
  end

  // sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      rej_q       <= 1'b0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            cur_q <= in_src_ext[SW-1:0];
            rej_q <= rejected;
            n_q   <= '0;
          end
        end
        ST_CHECK: cur_q <= '0;
        ST_LAT_EV: cur_q <= last_s ? '0 : cur_q + 1'b1;
        ST_FIN_EV: begin
          if (!fin_drop) begin
            if (!last_s) begin
              cur_q <= cur_q + 1'b1;
            end else if (!fin_better) begin
              cur_q <= early_src_q;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            pend_v_q <= 1'b1;
            n_q      <= n_q + 1'b1;
          end
        end
        ST_FINAL: if (slot_free) pend_v_q <= 1'b0;
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept) begin
      in_b_q <= {in_item_i.begin_sec, in_item_i.begin_nsec};
      in_f_q <= {in_item_i.finish_sec, in_item_i.finish_nsec};
    end
    if (state_q == ST_LAT_EV && ((cur_q == '0) || (rd_begin > latest_q))) begin
      latest_q <= rd_begin;
    end
    if (state_q == ST_FIN_EV && !fin_drop && fin_better) begin
      early_q     <= rd_finish;
      early_src_q <= cur_q;
    end
    if (state_q == ST_EMIT && emit_go) begin
      pend_q <= {latest_q, early_q};
    end
    if (out_load) begin
      out_q <= out_next;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `include "three_way_interval_intersection_assert.svh"

  `TWII_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> state_q == ST_IDLE)
  `TWII_ASSERT(a_accept_next, in_accept |=> (state_q == ST_WRITE || state_q == ST_CHECK))
  `TWII_ASSERT(a_emit_ordered, state_q == ST_EMIT |-> latest_q < early_q)
  `TWII_ASSERT(a_count_cap, n_q <= NW'(MaxResults))
  `TWII_ASSERT(a_tail_last, out_valid_o && out_item_o.kind != KIND_COMMON |-> out_item_o.last)

endmodule

// ===== bench/interval_intersection_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval intersection scoreboard
// Watches both channels of the block. For each accepted input item it works
// out the expected common, none or drop results from its own copy of the
// three source FIFOs, then compares every output item field by field, in order.
// ----------------------------------------------------------------------------
module interval_intersection_checker #(
  parameter int Depth  = twii_pkg::FifoDepthDef,
  parameter int NumSrc = twii_pkg::SourcesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  twii_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  twii_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  import twii_pkg::*;

  localparam int RingDepth = 256;

  logic [TimeW-1:0] start_mem [NumSrc][Depth];
  logic [TimeW-1:0] end_mem   [NumSrc][Depth];
  int               head_ptr  [NumSrc];
  int               depth_used[NumSrc];
  // expected items in order, oldest at pred_head
  out_item_t        pred_ring [RingDepth];
  int               pred_head  = 0;
  int               pred_count = 0;
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    mismatches++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
  endtask

  function automatic out_item_t interval_result(input logic [1:0] kind,
                                                input logic [TimeW-1:0] b,
                                                input logic [TimeW-1:0] f);
    out_item_t r;
    r.kind               = kind;
    r.common_begin_sec   = b[TimeW-1:NsecW];
    r.common_begin_nsec  = b[NsecW-1:0];
    r.common_finish_sec  = f[TimeW-1:NsecW];
    r.common_finish_nsec = f[NsecW-1:0];
    r.last               = 1'b0;
    return r;
  endfunction

  task automatic add_predicted(input out_item_t r);
    pred_ring[(pred_head + pred_count) % RingDepth] = r;
    pred_count++;
  endtask

  task automatic pop_head(input int s);
    head_ptr[s]   = (head_ptr[s] + 1) % Depth;
    depth_used[s] = depth_used[s] - 1;
  endtask

  task automatic predict_push(input in_item_t it);
    logic [TimeW-1:0] b, f, latest, earliest;
    int               src, slot, n, cap, earliest_src;
    bit               rejected, all_ready, dropped;
    b        = {it.begin_sec, it.begin_nsec};
    f        = {it.finish_sec, it.finish_nsec};
    src      = it.source;
    rejected = (src >= NumSrc) || (depth_used[src] >= Depth);
    if (!rejected) begin
      slot                = (head_ptr[src] + depth_used[src]) % Depth;
      start_mem[src][slot] = b;
      end_mem[src][slot]   = f;
      depth_used[src]++;
    end

    cap = MaxResults - (rejected ? 1 : 0);
    n   = 0;
    while (n < cap) begin
      all_ready = 1'b1;
      for (int s = 0; s < NumSrc; s++)
        if (depth_used[s] == 0) all_ready = 1'b0;
      if (!all_ready) break;

      latest = start_mem[0][head_ptr[0]];
      for (int s = 1; s < NumSrc; s++)
        if (start_mem[s][head_ptr[s]] > latest) latest = start_mem[s][head_ptr[s]];

      // stale heads go first, lowest source wins, then rescan
      dropped = 1'b0;
      for (int s = 0; s < NumSrc; s++) begin
        if (end_mem[s][head_ptr[s]] <= latest) begin
          pop_head(s);
          dropped = 1'b1;
          break;
        end
      end
      if (dropped) continue;

      earliest     = end_mem[0][head_ptr[0]];
      earliest_src = 0;
      for (int s = 1; s < NumSrc; s++) begin
        if (end_mem[s][head_ptr[s]] < earliest) begin
          earliest     = end_mem[s][head_ptr[s]];
          earliest_src = s;
        end
      end
      add_predicted(interval_result(KIND_COMMON, latest, earliest));
      n++;
      pop_head(earliest_src);
    end

    if (rejected) begin
      add_predicted(interval_result(KIND_DROP, '0, '0));
    end else if (n == 0) begin
      add_predicted(interval_result(KIND_NONE, '0, '0));
    end
    pred_ring[(pred_head + pred_count - 1) % RingDepth].last = 1'b1;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pred_count == 0) begin
      report_mismatch("item with nothing expected, kind", 64'(got.kind), '0);
      return;
    end
    want       = pred_ring[pred_head];
    pred_head  = (pred_head + 1) % RingDepth;
    pred_count = pred_count - 1;
    if (got.kind !== want.kind)
      report_mismatch("kind", 64'(got.kind), 64'(want.kind));
    if (got.common_begin_sec !== want.common_begin_sec)
      report_mismatch("common_begin_sec", 64'(got.common_begin_sec),
                      64'(want.common_begin_sec));
    if (got.common_begin_nsec !== want.common_begin_nsec)
      report_mismatch("common_begin_nsec", 64'(got.common_begin_nsec),
                      64'(want.common_begin_nsec));
    if (got.common_finish_sec !== want.common_finish_sec)
      report_mismatch("common_finish_sec", 64'(got.common_finish_sec),
                      64'(want.common_finish_sec));
    if (got.common_finish_nsec !== want.common_finish_nsec)
      report_mismatch("common_finish_nsec", 64'(got.common_finish_nsec),
                      64'(want.common_finish_nsec));
    if (got.last !== want.last)
      report_mismatch("last", 64'(got.last), 64'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSrc; s++) begin
        head_ptr[s]   = 0;
        depth_used[s] = 0;
      end
      pred_head  = 0;
      pred_count = 0;
      pending_o <= 0;
    end else begin
      // results of an earlier item can share an edge with the next push
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) predict_push(in_item_i);
      pending_o <= pred_count;
    end
  end

endmodule

// ===== bench/tb_three_way_interval_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-way interval intersection testbench
// Directed pushes cover full and out-of-range sources, malformed and touching
// intervals and long drains; then random sessions of time-ordered intervals
// per source, mixed with noise, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_three_way_interval_intersection;
  import twii_pkg::*;

  localparam logic [TimeW-1:0] TimeMax  = '1;
  localparam logic [TimeW-1:0] OneSecHi = {32'd1, {NsecW{1'b1}}};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending_results;

  int               burst_left  = 0;
  logic [8:0]       stall_cycle = '0;
  logic [TimeW-1:0] cursor [SourcesDef];

  three_way_interval_intersection dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  interval_intersection_checker u_sb (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .fail_count_o(fail_count),
    .pending_o   (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: quiet, light, medium and heavy stall windows in turn
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 9'd1;
    case (stall_cycle[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  function automatic in_item_t pack_interval(input logic [1:0] src,
                                             input logic [TimeW-1:0] b,
                                             input logic [TimeW-1:0] f);
    in_item_t it;
    it.source      = src;
    it.begin_sec   = b[TimeW-1:NsecW];
    it.begin_nsec  = b[NsecW-1:0];
    it.finish_sec  = f[TimeW-1:NsecW];
    it.finish_nsec = f[NsecW-1:0];
    return it;
  endfunction

  function automatic logic [TimeW-1:0] random_time();
    logic [31:0] hi, lo;
    hi = $urandom;
    lo = $urandom;
    return {hi, lo[NsecW-1:0]};
  endfunction

  task automatic send_interval(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(0, 5);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // next interval of a source, after its previous one; gaps may be zero
  task automatic send_ordered(input logic [1:0] src);
    logic [TimeW-1:0] b, f;
    b = cursor[src];
    if ($urandom_range(0, 3) != 0) b = b + TimeW'($urandom_range(1, 1_000_000_000));
    f = b + TimeW'($urandom_range(1, 32'd3_000_000_000));
    cursor[src] = f;
    send_interval(pack_interval(src, b, f));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0]      base_sec, base_lo;
    logic [TimeW-1:0] base, b, f;
    logic [1:0]       src, prev_src;
    int               pick;
    prev_src = 2'd0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // fill source 0 past its depth: the last push is dropped
    for (int k = 0; k < 17; k++)
      send_interval(pack_interval(2'd0, TimeW'(k * 1000 + 100), TimeW'(k * 1000 + 600)));
    send_interval(pack_interval(2'd3, TimeMax, TimeMax));
    send_interval(pack_interval(2'd1, '0, TimeW'(20000)));
    // this one drains all of source 0 in one go
    send_interval(pack_interval(2'd2, '0, TimeW'(20000)));
    // ends before it starts
    send_interval(pack_interval(2'd0, TimeW'(25000), TimeW'(24000)));
    // nanoseconds above a billion; stale heads of sources 1 and 2 fall out
    send_interval(pack_interval(2'd0, TimeW'(1_000_000_005), OneSecHi));
    send_interval(pack_interval(2'd1, TimeW'(1_000_000_000), OneSecHi));
    // equal ends on sources 0 and 1
    send_interval(pack_interval(2'd2, TimeW'(999_999_999), {32'd3, {NsecW{1'b0}}}));
    // end of one interval equal to the latest start
    send_interval(pack_interval(2'd0, OneSecHi, {32'd2, {NsecW{1'b0}}}));

    for (int sess = 0; sess < 7; sess++) begin
      wait_drained();
      // each session starts later than all but the random intervals before it
      base_sec = sess * 32'h2000_0000 + $urandom_range(16, 32'h0FFF_FFFF);
      base_lo  = $urandom;
      base     = {base_sec, base_lo[NsecW-1:0]};
      for (int s = 0; s < SourcesDef; s++) cursor[s] = base;

      if (sess % 3 == 1) begin
        src = 2'($urandom_range(0, 2));
        repeat (18) send_ordered(src);
      end

      repeat (40) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) src = prev_src;
        else src = 2'($urandom_range(0, 2));
        if (pick < 78) begin
          send_ordered(src);
        end else if (pick < 88) begin
          send_interval(pack_interval(2'd3, random_time(), random_time()));
        end else if (pick < 98) begin
          b = cursor[src] + TimeW'($urandom_range(0, 1_000_000_000));
          f = b - TimeW'($urandom_range(0, 1_000_000_000));
          send_interval(pack_interval(src, b, f));
        end else begin
          send_interval(pack_interval(src, random_time(), random_time()));
        end
        prev_src = src;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== three_way_interval_intersection.f =====
+incdir+hdl
hdl/twii_pkg.sv
hdl/twii_ram.sv
hdl/three_way_interval_intersection.sv
bench/interval_intersection_checker.sv
bench/tb_three_way_interval_intersection.sv
